/* rtl/core/diff_drive_odometry_macros.svh */
// Assertion helpers used by the odometry RTL.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// Check a property on every clock while out of reset.
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define DDO_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/ddo_pkg.sv */
package ddo_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int CORDIC_STEPS     = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] REG_INVERT_LEFT  = 3'd0;
    localparam logic [2:0] REG_INVERT_RIGHT = 3'd1;
    localparam logic [2:0] REG_DIST_PER_CNT = 3'd2;
    localparam logic [2:0] REG_HEADING_GAIN = 3'd3;
    localparam logic [2:0] REG_MIN_INTERVAL = 3'd4;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic        [31:0] sample_time;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic               pose_updated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_PREP,
        ST_MUL2,
        ST_FINISH,
        ST_WRITE
    } state_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                5'd24:   v = 32'h00000029;
                5'd25:   v = 32'h00000014;
                5'd26:   v = 32'h0000000A;
                5'd27:   v = 32'h00000005;
                5'd28:   v = 32'h00000003;
                5'd29:   v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_entry = v;
        end
    endfunction

endpackage

/* rtl/core/diff_drive_odometry.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | ddo_pkg::in_item_t
// out     | output    | out_valid/out_ready| ddo_pkg::out_item_t
// cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// A moving sample passes through the bit-serial count-to-distance multiply (the 30-step
// CORDIC runs alongside), a combine step, the serial heading and position multiplies,
// a pose update and the load of the output register before out_valid rises; the block
// is ready for the next input transfer when out_valid rises. A priming or idle sample
// goes straight to the output register. One sample is in work at a time.
// Reset clears the pose, the baseline and the registers to their defaults.
// A result waiting at out does not block the next input transfer; the block
// holds in its write state only when the next result finds out still full.
`include "diff_drive_odometry_macros.svh"

module diff_drive_odometry (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ddo_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ddo_pkg::out_item_t out_data,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SHIFT_K = 32 - ddo_pkg::SINE_IDX_W;

    ddo_pkg::state_t state_reg, state_next;

    logic        invert_left_reg, invert_right_reg;
    logic [31:0] dist_per_cnt_reg;
    logic [23:0] heading_gain_reg;
    logic [19:0] min_interval_reg;

    logic [31:0]        base_left_reg, base_right_reg, base_time_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic [31:0]        acc_heading_reg;
    logic               primed_reg;

    logic [31:0] left_reg, right_reg, time_reg;
    logic        updated_reg;
    logic [4:0]  cnt_reg;

    logic signed [63:0] ml_reg, mr_reg, prodl_reg, prodr_reg;
    logic [31:0]        dpc_sh_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;

    logic signed [63:0] mx_reg, px_reg, py_reg;
    logic [23:0]        cs_sh_reg, sn_sh_reg, gain_sh_reg;
    logic [39:0]        hm_reg, hacc_reg;

    logic               out_valid_reg;
    ddo_pkg::out_item_t out_data_reg;

    // control
    logic accept, write_ok, go, last_mul1, last_mul2;

    // input side
    logic [31:0] inv_l, inv_r, dl, dr, elapsed;
    logic [31:0] k_sum, ang;

    // combine
    logic signed [55:0] distl, distr;
    logic signed [56:0] dsum, ddiff, dd57;
    logic signed [39:0] dd40;
    logic signed [33:0] xf, yf, xr, yr;
    logic signed [33:0] dxs, dys;
    logic [31:0]        atan_v;

    // finish
    logic signed [35:0] sx, sy, stx, sty;
    logic signed [31:0] new_x, new_y;

    assign accept    = in_valid && in_ready;
    assign write_ok  = !out_valid_reg || out_ready;
    assign last_mul1 = (cnt_reg == 5'd31);
    assign last_mul2 = (cnt_reg == 5'd23);

    always_comb
    begin
        inv_l   = invert_left_reg  ? 32'd0 - in_data.left_count  : in_data.left_count;
        inv_r   = invert_right_reg ? 32'd0 - in_data.right_count : in_data.right_count;
        dl      = inv_l - base_left_reg;
        dr      = inv_r - base_right_reg;
        elapsed = in_data.sample_time - base_time_reg;
        go      = primed_reg && ((dl != 32'd0) || (dr != 32'd0))
                  && (elapsed > {12'd0, min_interval_reg});
        // round the heading to the nearest table angle
        k_sum   = acc_heading_reg + (32'd1 << (SHIFT_K - 1));
        ang     = {k_sum[31:SHIFT_K], {SHIFT_K{1'b0}}};
    end

    always_comb
    begin
        dxs    = cy_reg >>> cnt_reg;
        dys    = cx_reg >>> cnt_reg;
        atan_v = ddo_pkg::atan_entry(cnt_reg);
    end

    always_comb
    begin
        distl = prodl_reg[63:8];
        distr = prodr_reg[63:8];
        dsum  = 57'(distl) + 57'(distr);
        ddiff = 57'(distl) - 57'(distr);
        dd57  = dsum >>> 1;
        if (dd57 > 57'sd549755813887)
            dd40 = 40'sh7F_FFFF_FFFF;
        else if (dd57 < -57'sd549755813888)
            dd40 = 40'sh80_0000_0000;
        else
            dd40 = dd57[39:0];
        xf = flip_reg ? -cx_reg : cx_reg;
        yf = flip_reg ? -cy_reg : cy_reg;
        xr = (xf + 34'sd128) >>> 8;
        yr = (yf + 34'sd128) >>> 8;
    end

    always_comb
    begin
        stx = 36'(px_reg >>> 30);
        sty = 36'(py_reg >>> 30);
        sx  = 36'(acc_x_reg) + stx;
        sy  = 36'(acc_y_reg) + sty;
        if (sx > 36'sd2147483647)
            new_x = 32'sh7FFF_FFFF;
        else if (sx < -36'sd2147483648)
            new_x = 32'sh8000_0000;
        else
            new_x = sx[31:0];
        if (sy > 36'sd2147483647)
            new_y = 32'sh7FFF_FFFF;
        else if (sy < -36'sd2147483648)
            new_y = 32'sh8000_0000;
        else
            new_y = sy[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE:
                if (accept)
                    state_next = go ? ddo_pkg::ST_MUL1 : ddo_pkg::ST_WRITE;
            ddo_pkg::ST_MUL1:
                if (last_mul1)
                    state_next = ddo_pkg::ST_PREP;
            ddo_pkg::ST_PREP:
                state_next = ddo_pkg::ST_MUL2;
            ddo_pkg::ST_MUL2:
                if (last_mul2)
                    state_next = ddo_pkg::ST_FINISH;
            ddo_pkg::ST_FINISH:
                state_next = ddo_pkg::ST_WRITE;
            ddo_pkg::ST_WRITE:
                if (write_ok)
                    state_next = ddo_pkg::ST_IDLE;
            default:
                state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ddo_pkg::ST_IDLE);
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_left_reg  <= 1'b0;
            invert_right_reg <= 1'b1;
            dist_per_cnt_reg <= 32'd81989;
            heading_gain_reg <= 24'd17099;
            min_interval_reg <= 20'd10000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ddo_pkg::REG_INVERT_LEFT:  invert_left_reg  <= cfg_data[0];
                ddo_pkg::REG_INVERT_RIGHT: invert_right_reg <= cfg_data[0];
                ddo_pkg::REG_DIST_PER_CNT: dist_per_cnt_reg <= cfg_data;
                ddo_pkg::REG_HEADING_GAIN: heading_gain_reg <= cfg_data[23:0];
                ddo_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // pose, baseline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_left_reg   <= '0;
            base_right_reg  <= '0;
            base_time_reg   <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            primed_reg      <= 1'b0;
            updated_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                updated_reg <= 1'b0;
                if (!primed_reg)
                begin
                    base_left_reg  <= inv_l;
                    base_right_reg <= inv_r;
                    base_time_reg  <= in_data.sample_time;
                    primed_reg     <= 1'b1;
                end
            end
            if (state_reg == ddo_pkg::ST_FINISH)
            begin
                acc_x_reg       <= new_x;
                acc_y_reg       <= new_y;
                acc_heading_reg <= acc_heading_reg + hacc_reg[39:8];
                base_left_reg   <= left_reg;
                base_right_reg  <= right_reg;
                base_time_reg   <= time_reg;
                updated_reg     <= 1'b1;
            end
            if (state_reg == ddo_pkg::ST_WRITE && write_ok)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                left_reg   <= inv_l;
                right_reg  <= inv_r;
                time_reg   <= in_data.sample_time;
                ml_reg     <= 64'(signed'(dl));
                mr_reg     <= 64'(signed'(dr));
                prodl_reg  <= '0;
                prodr_reg  <= '0;
                dpc_sh_reg <= dist_per_cnt_reg;
                cnt_reg    <= '0;
                cx_reg     <= ddo_pkg::CORDIC_GAIN;
                cy_reg     <= '0;
                // turn the back half-plane by half a turn, negate at the end
                if (ang[31] != ang[30])
                begin
                    flip_reg <= 1'b1;
                    cz_reg   <= 34'(signed'(ang - 32'h8000_0000));
                end
                else
                begin
                    flip_reg <= 1'b0;
                    cz_reg   <= 34'(signed'(ang));
                end
            end
            ddo_pkg::ST_MUL1:
            begin
                if (dpc_sh_reg[0])
                begin
                    prodl_reg <= prodl_reg + ml_reg;
                    prodr_reg <= prodr_reg + mr_reg;
                end
                ml_reg     <= ml_reg <<< 1;
                mr_reg     <= mr_reg <<< 1;
                dpc_sh_reg <= dpc_sh_reg >> 1;
                if (cnt_reg < 5'(ddo_pkg::CORDIC_STEPS))
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - dxs;
                        cy_reg <= cy_reg + dys;
                        cz_reg <= cz_reg - 34'(atan_v);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + dxs;
                        cy_reg <= cy_reg - dys;
                        cz_reg <= cz_reg + 34'(atan_v);
                    end
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            ddo_pkg::ST_PREP:
            begin
                mx_reg      <= 64'(dd40);
                hm_reg      <= ddiff[39:0];
                cs_sh_reg   <= xr[23:0];
                sn_sh_reg   <= yr[23:0];
                gain_sh_reg <= heading_gain_reg;
                hacc_reg    <= '0;
                px_reg      <= '0;
                py_reg      <= '0;
                cnt_reg     <= '0;
            end
            ddo_pkg::ST_MUL2:
            begin
                if (gain_sh_reg[0])
                    hacc_reg <= hacc_reg + hm_reg;
                hm_reg      <= hm_reg << 1;
                gain_sh_reg <= gain_sh_reg >> 1;
                // top bit of a signed multiplier carries negative weight
                if (cs_sh_reg[0])
                    px_reg <= last_mul2 ? px_reg - mx_reg : px_reg + mx_reg;
                if (sn_sh_reg[0])
                    py_reg <= last_mul2 ? py_reg - mx_reg : py_reg + mx_reg;
                mx_reg    <= mx_reg <<< 1;
                cs_sh_reg <= cs_sh_reg >> 1;
                sn_sh_reg <= sn_sh_reg >> 1;
                cnt_reg   <= cnt_reg + 5'd1;
            end
            ddo_pkg::ST_WRITE:
            begin
                if (write_ok)
                begin
                    out_data_reg.pos_x        <= acc_x_reg;
                    out_data_reg.pos_y        <= acc_y_reg;
                    out_data_reg.heading      <= acc_heading_reg;
                    out_data_reg.pose_updated <= updated_reg;
                end
            end
            default: ;
        endcase
    end

    `DDO_ASSERT_NEXT(a_one_in_flight, accept, !in_ready, "input taken while busy")
    `DDO_ASSERT(a_update_needs_prime,
        !(out_valid_reg && out_data_reg.pose_updated) || primed_reg,
        "pose update without baseline")
    `DDO_ASSERT(a_mul2_count, (state_reg != ddo_pkg::ST_MUL2) || (cnt_reg < 5'd24),
        "serial multiply overran")

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 20000;
    localparam int ODO_STEPS      = 30;
    localparam int ODO_DEPTH      = 1024;

    // Per-step CORDIC angles, full turn = 2^32.
    localparam logic [31:0] ARC_ANGLE [ODO_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    class pose_scoreboard;
        bit         inv_l;
        bit         inv_r;
        logic [31:0] dist_scale;
        logic [23:0] turn_gain;
        logic [19:0] hold_us;
        logic [31:0] ref_l;
        logic [31:0] ref_r;
        logic [31:0] ref_t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0] hdg;
        bit         primed;
        ddo_pkg::out_item_t  pending[$];
        int         mismatches;
        int         checked;
        int         moves;

        function void clear();
            inv_l = 0;
            inv_r = 1;
            dist_scale = 32'd81989;
            turn_gain = 24'd17099;
            hold_us = 20'd10000;
            ref_l = 0;
            ref_r = 0;
            ref_t = 0;
            px = 0;
            py = 0;
            hdg = 0;
            primed = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                ddo_pkg::REG_INVERT_LEFT:  inv_l = val[0];
                ddo_pkg::REG_INVERT_RIGHT: inv_r = val[0];
                ddo_pkg::REG_DIST_PER_CNT: dist_scale = val;
                ddo_pkg::REG_HEADING_GAIN: turn_gain = val[23:0];
                ddo_pkg::REG_MIN_INTERVAL: hold_us = val[19:0];
                default: ;
            endcase
        endfunction

        // Cos and sin of the table angle nearest h, Q22.
        function void trig_q22(logic [31:0] h, output longint c22, output longint s22);
            longint unsigned k;
            logic [31:0] a;
            bit flip;
            longint x, y, z, dx, dy;
            k = ({32'd0, h} * ODO_DEPTH + 64'h80000000) >> 32;
            if (k >= ODO_DEPTH)
                k = 0;
            a = 32'((k << 32) / ODO_DEPTH);
            flip = 0;
            if (((a + 32'h40000000) & 32'h80000000) != 0)
            begin
                a = a - 32'h80000000;
                flip = 1;
            end
            x = 652032874;
            y = 0;
            z = longint'($signed(a));
            for (int i = 0; i < ODO_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= longint'(ARC_ANGLE[i]);
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += longint'(ARC_ANGLE[i]);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c22 = (x + 128) >>> 8;
            s22 = (y + 128) >>> 8;
        endfunction

        function logic signed [31:0] clamp_add(logic signed [31:0] a, longint stepv);
            longint r;
            r = longint'(a) + stepv;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_sample(ddo_pkg::in_item_t s);
            logic [31:0] l, r, el;
            longint dl, dr, distl, distr, dd, c22, s22;
            logic [63:0] prod;
            ddo_pkg::out_item_t o;
            bit upd;
            l = inv_l ? -s.left_count : s.left_count;
            r = inv_r ? -s.right_count : s.right_count;
            upd = 0;
            if (!primed)
            begin
                ref_l = l;
                ref_r = r;
                ref_t = s.sample_time;
                primed = 1;
            end
            else
            begin
                dl = longint'($signed(l - ref_l));
                dr = longint'($signed(r - ref_r));
                el = s.sample_time - ref_t;
                if ((dl != 0 || dr != 0) && el > {12'd0, hold_us})
                begin
                    distl = (dl * longint'({32'd0, dist_scale})) >>> 8;
                    distr = (dr * longint'({32'd0, dist_scale})) >>> 8;
                    dd = (distl + distr) >>> 1;
                    prod = 64'(distl - distr) * {40'd0, turn_gain};
                    if (dd > (64'sd1 <<< 39) - 1)
                        dd = (64'sd1 <<< 39) - 1;
                    if (dd < -(64'sd1 <<< 39))
                        dd = -(64'sd1 <<< 39);
                    trig_q22(hdg, c22, s22);
                    px = clamp_add(px, (dd * c22) >>> 30);
                    py = clamp_add(py, (dd * s22) >>> 30);
                    hdg = hdg + prod[39:8];
                    ref_l = l;
                    ref_r = r;
                    ref_t = s.sample_time;
                    upd = 1;
                    moves++;
                end
            end
            o.pos_x = px;
            o.pos_y = py;
            o.heading = hdg;
            o.pose_updated = upd;
            pending.push_back(o);
        endfunction

        function void check_pose(ddo_pkg::out_item_t got);
            ddo_pkg::out_item_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose x=%h y=%h h=%h u=%b",
                             got.pos_x, got.pos_y, got.heading, got.pose_updated);
                return;
            end
            want = pending.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.heading !== want.heading || got.pose_updated !== want.pose_updated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pose mismatch: want x=%h y=%h h=%h u=%b got x=%h y=%h h=%h u=%b",
                             want.pos_x, want.pos_y, want.heading, want.pose_updated,
                             got.pos_x, got.pos_y, got.heading, got.pose_updated);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    ddo_pkg::in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    ddo_pkg::out_item_t  out_data;
    logic       cfg_write;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    pose_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  sent;

    // Running sample state for well-formed motion.
    logic signed [31:0] run_l;
    logic signed [31:0] run_r;
    logic [31:0] run_t;

    diff_drive_odometry dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        board = new();
        board.clear();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
    end

    // Receiver: random stall, or a long hold-off when requested.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready && rst_n)
                board.check_pose(out_data);
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on transfers.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_sample(logic [31:0] l, logic [31:0] r, logic [31:0] t);
        ddo_pkg::in_item_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        s.left_count = l;
        s.right_count = r;
        s.sample_time = t;
        in_valid <= 1;
        in_data <= s;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_sample(s);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.set_reg(idx, val);
        cfg_write <= 0;
        @(posedge clk);
    endtask

    // Step the running counts and time; mostly plausible motion.
    task automatic move_step(int span);
        int dl, dr;
        dl = $urandom_range(2 * span) - span;
        dr = $urandom_range(2 * span) - span;
        if ($urandom_range(9) == 0)
            dl = 0;
        run_l = run_l + dl;
        run_r = run_r + dr;
        if ($urandom_range(9) == 0)
            run_t = run_t + $urandom_range(board.hold_us);
        else
            run_t = run_t + board.hold_us + 1 + $urandom_range(30000);
        send_sample(run_l, run_r, run_t);
    endtask

    task automatic random_phase(int n, int span);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                send_sample($urandom, $urandom, $urandom);
            else
                move_step(span);
        end
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        sent = 0;
        run_l = 0;
        run_r = 0;
        run_t = 0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: priming, no motion, too early, exact interval, rollover, extremes.
        send_sample(32'd100, 32'd100, 32'd1000);
        send_sample(32'd100, 32'd100, 32'd50000);
        send_sample(32'd200, 32'd150, 32'd5000);
        send_sample(32'd200, 32'd150, 32'd11000);
        send_sample(32'd300, 32'd90, 32'd21001);
        send_sample(32'h7FFFFFFF, 32'h80000000, 32'd40000);
        send_sample(32'h80000005, 32'h7FFFFFF0, 32'd60000);
        send_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFF00);
        send_sample(32'h00000010, 32'h00000020, 32'h00010000);
        send_sample(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_sample(32'h00000000, 32'h00000000, 32'h00000000);
        drain();
        write_reg(ddo_pkg::REG_INVERT_LEFT, 32'd1);
        write_reg(ddo_pkg::REG_INVERT_RIGHT, 32'd0);
        write_reg(ddo_pkg::REG_DIST_PER_CNT, 32'hFFFFFFFF);
        write_reg(ddo_pkg::REG_HEADING_GAIN, 32'hFFFFFFFF);
        write_reg(ddo_pkg::REG_MIN_INTERVAL, 32'd0);
        write_reg(3'd7, 32'h12345678);
        // Full-scale travel: position saturation and heading wrap.
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? 32'h7FFFFFFF : 32'h80000000,
                        i[1] ? 32'h80000000 : 32'h7FFFFFFF, 32'd100 * i + 1);
        send_sample(32'h1, 32'h1, 32'h5);
        send_sample(32'h1, 32'h1, 32'h5);
        drain();

        write_reg(ddo_pkg::REG_INVERT_LEFT, 32'd0);
        write_reg(ddo_pkg::REG_INVERT_RIGHT, 32'd1);
        write_reg(ddo_pkg::REG_DIST_PER_CNT, 32'd81989);
        write_reg(ddo_pkg::REG_HEADING_GAIN, 32'd17099);
        write_reg(ddo_pkg::REG_MIN_INTERVAL, 32'd1000000);
        random_phase(60, 3000);

        drain();
        write_reg(ddo_pkg::REG_MIN_INTERVAL, 32'd10000);
        write_reg(ddo_pkg::REG_HEADING_GAIN, 32'd16777215);
        send_idle_pct = 73;
        random_phase(120, 500);

        // Fill the block while the receiver holds off.
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            random_phase(20, 2000);
        join
        drain();

        write_reg(ddo_pkg::REG_DIST_PER_CNT, 32'd0);
        write_reg(ddo_pkg::REG_INVERT_LEFT, 32'd1);
        recv_stall_pct = 73;
        random_phase(100, 100000);

        drain();
        write_reg(ddo_pkg::REG_DIST_PER_CNT, $urandom);
        write_reg(ddo_pkg::REG_HEADING_GAIN, $urandom_range(200000));
        write_reg(ddo_pkg::REG_MIN_INTERVAL, $urandom_range(20000));
        send_idle_pct = 21;
        recv_stall_pct = 21;
        random_phase(130, 40000);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(120, 2000000000);

        drain();
        $display("covered %0d samples, %0d poses checked, %0d pose advances",
                 sent, board.checked, board.moves);
        $display("register extremes, saturation, wrap, priming and stall phases exercised");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* diff_drive_odometry.f */
+incdir+rtl/core
rtl/core/ddo_pkg.sv
rtl/core/diff_drive_odometry.sv
sim/tb.sv
